// ===== rtl/core/gtst_pkg.sv =====
// Package for the generational texture slot table.
// Holds the opcodes, status codes, slot entry layout and the word and command types.
// No dependencies; the controller, datapath, top level and testbench import it.
package gtst_pkg;

   localparam int SLOT_COUNT = 1024;
   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
   localparam int MAX_EXTENT = 8192;

   localparam logic [31:0] GEN_MAX       = 32'hFFFF_FFFF;
   localparam logic [15:0] DEVICE_RESET  = 16'd1;
   localparam logic [31:0] BUDGET_RESET  = 32'h1000_0000;

   localparam logic CSR_DEVICE_ID   = 1'b0;
   localparam logic CSR_BYTE_BUDGET = 1'b1;

   localparam logic [3:0] OP_ALLOC       = 4'd0;
   localparam logic [3:0] OP_ALLOC_DEPTH = 4'd1;
   localparam logic [3:0] OP_RETAIN      = 4'd2;
   localparam logic [3:0] OP_RELEASE     = 4'd3;
   localparam logic [3:0] OP_RESERVE     = 4'd4;
   localparam logic [3:0] OP_DROP        = 4'd5;
   localparam logic [3:0] OP_QUERY       = 4'd6;
   localparam logic [3:0] OP_MARK        = 4'd7;
   localparam logic [3:0] OP_BEGIN_FRAME = 4'd8;
   localparam logic [3:0] OP_CHECK       = 4'd9;
   localparam logic [3:0] OP_INVALIDATE  = 4'd10;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_STALE     = 4'd1;
   localparam logic [3:0] ST_PRECISION = 4'd2;
   localparam logic [3:0] ST_SIZE      = 4'd3;
   localparam logic [3:0] ST_BYTES     = 4'd4;
   localparam logic [3:0] ST_SLOTS     = 4'd5;
   localparam logic [3:0] ST_OWNERS    = 4'd6;
   localparam logic [3:0] ST_LOST      = 4'd7;
   localparam logic [3:0] ST_UPLOAD    = 4'd8;
   localparam logic [3:0] ST_SAMPLED   = 4'd9;
   localparam logic [3:0] ST_DEPTH     = 4'd10;
   localparam logic [3:0] ST_TARGET    = 4'd11;

   // Bit positions in the attribute field of a slot.
   localparam int AB_PREC     = 0;
   localparam int AB_DEPTHTEX = 1;
   localparam int AB_TARGET   = 2;
   localparam int AB_PLANE    = 3;
   localparam int AB_SAMPLED  = 4;

   typedef struct packed {
      logic        live;
      logic [31:0] generation;
      logic [31:0] owners;
      logic [13:0] width;
      logic [13:0] height;
      logic [4:0]  attrs;
   } entry_type;

   typedef struct packed {
      logic [3:0]       opcode;
      logic [15:0]      handle_device;
      logic [IDX_W-1:0] handle_slot;
      logic [31:0]      handle_generation;
      logic [13:0]      req_width;
      logic [13:0]      req_height;
      logic [1:0]       req_precision;
      logic [29:0]      upload_length;
   } req_word_type;

   typedef struct packed {
      logic [3:0]       status;
      logic             done_flag;
      logic [IDX_W-1:0] out_slot;
      logic [31:0]      out_generation;
      logic [13:0]      out_width;
      logic [13:0]      out_height;
      logic             out_precision;
      logic             out_is_depth;
      logic             out_is_target;
      logic [CNT_W-1:0] live_textures;
      logic [31:0]      texture_bytes;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic read;
      logic mult;
      logic sweep_start;
      logic step;
      logic finish;
      logic phase2;
   } dp_cmd_type;

   typedef struct packed {
      logic defer;
      logic sweep_end;
   } dp_stat_type;

endpackage

// ===== rtl/core/gtst_req_if.sv =====
// Command channel of the texture slot table: valid, ready and the command word fields.
// No dependencies.
interface gtst_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  opcode;
   logic [15:0] handle_device;
   logic [9:0]  handle_slot;
   logic [31:0] handle_generation;
   logic [13:0] req_width;
   logic [13:0] req_height;
   logic [1:0]  req_precision;
   logic [29:0] upload_length;

   modport source (output valid, output opcode, output handle_device, output handle_slot,
                   output handle_generation, output req_width, output req_height,
                   output req_precision, output upload_length, input ready);
   modport sink (input valid, input opcode, input handle_device, input handle_slot,
                 input handle_generation, input req_width, input req_height,
                 input req_precision, input upload_length, output ready);
endinterface

// ===== rtl/core/gtst_rsp_if.sv =====
// Result channel of the texture slot table: valid, ready and the result word fields.
// No dependencies.
interface gtst_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic        done_flag;
   logic [9:0]  out_slot;
   logic [31:0] out_generation;
   logic [13:0] out_width;
   logic [13:0] out_height;
   logic        out_precision;
   logic        out_is_depth;
   logic        out_is_target;
   logic [10:0] live_textures;
   logic [31:0] texture_bytes;

   modport source (output valid, output status, output done_flag, output out_slot,
                   output out_generation, output out_width, output out_height,
                   output out_precision, output out_is_depth, output out_is_target,
                   output live_textures, output texture_bytes, input ready);
   modport sink (input valid, input status, input done_flag, input out_slot,
                 input out_generation, input out_width, input out_height,
                 input out_precision, input out_is_depth, input out_is_target,
                 input live_textures, input texture_bytes, output ready);
endinterface

// ===== rtl/core/gtst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gtst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/gtst_ctrl.sv =====
// Sequencer of the texture slot table: handshakes and the phase of the current command.
// Depends on gtst_pkg for the command and status types.
module gtst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output gtst_pkg::dp_cmd_type    cmd,
   input  gtst_pkg::dp_stat_type   stat
);
   import gtst_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_MULT  = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_SWEEP = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_MULT;
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (stat.defer) begin
               cmd.sweep_start = 1'b1;
               state_in = S_SWEEP;
            end else if (rsp_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SWEEP: begin
            cmd.step = 1'b1;
            if (stat.sweep_end) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.phase2 = 1'b1;
            if (rsp_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== rtl/core/gtst_dpath.sv =====
// Datapath of the texture slot table: slot RAM, counters, registers, multiplier and checks.
// Depends on gtst_pkg and gtst_ram.
module gtst_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_en,
   input  logic                    csr_index,
   input  logic [31:0]             csr_wdata,
   input  gtst_pkg::req_word_type  req_word,
   input  gtst_pkg::dp_cmd_type    cmd,
   output gtst_pkg::dp_stat_type   stat,
   output gtst_pkg::rsp_word_type  rsp_word
);
   import gtst_pkg::*;

   localparam int EW = $bits(entry_type);

   logic [15:0]      device_ff;
   logic [31:0]      budget_ff;
   logic [CNT_W-1:0] hw_ff, hw_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic [31:0]      bytes_ff, bytes_in;
   logic             lost_ff, lost_in;

   req_word_type     req_ff;
   rsp_word_type     rsp_ff;
   logic             own_ff;
   logic [27:0]      prod_ff;

   logic [CNT_W-1:0] scan_ff;
   logic             pend_ff;
   logic [IDX_W-1:0] pend_addr_ff;
   logic             found_ff;
   logic [IDX_W-1:0] found_slot_ff;
   logic [31:0]      found_gen_ff;

   logic             ram_we, ram_re;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   logic [EW-1:0]    ram_wdata, ram_rdata;
   entry_type        ent;

   logic             is_alloc, is_depth, valid, scan_more, free_hit, clr_we;
   logic [1:0]       a_prec;
   logic [29:0]      a_len;
   logic [29:0]      p4;
   logic [30:0]      p8;
   logic [30:0]      a_bytes;
   logic [31:0]      rel_bytes, add_x, sub_x, sub_res;
   logic [32:0]      add_sum;
   logic             fits;
   logic [3:0]       alloc_chk;
   logic [13:0]      mul_a, mul_b;

   logic [3:0]       fin_st;
   logic             fin_done, fin_we;
   logic [IDX_W-1:0] fin_slot, fin_addr;
   logic [31:0]      fin_gen;
   entry_type        fin_wdata, new_ent;
   logic [4:0]       new_attrs;

   gtst_ram #(.WIDTH(EW), .DEPTH(SLOT_COUNT)) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign ent      = entry_type'(ram_rdata);
   assign is_alloc = (req_ff.opcode == OP_ALLOC) || (req_ff.opcode == OP_ALLOC_DEPTH);
   assign is_depth = (req_ff.opcode == OP_ALLOC_DEPTH);
   assign valid    = own_ff && !lost_ff;
   assign a_prec   = is_depth ? 2'd0 : req_ff.req_precision;
   assign a_len    = is_depth ? 30'd0 : req_ff.upload_length;

   // One multiplier: requested extent for allocations, stored extent otherwise.
   assign mul_a = is_alloc ? req_ff.req_width  : ent.width;
   assign mul_b = is_alloc ? req_ff.req_height : ent.height;

   assign p4      = {prod_ff, 2'b00};
   assign p8      = {prod_ff, 3'b000};
   assign a_bytes = (a_prec == 2'd1) ? p8 : {1'b0, p4};
   assign rel_bytes = (ent.attrs[AB_PREC] ? {1'b0, p8} : {2'b00, p4})
                      + (ent.attrs[AB_PLANE] ? {2'b00, p4} : 32'd0);

   assign add_x   = is_alloc ? {1'b0, a_bytes} : {2'b00, p4};
   assign add_sum = {1'b0, bytes_ff} + {1'b0, add_x};
   assign fits    = add_sum <= {1'b0, budget_ff};
   assign sub_x   = (req_ff.opcode == OP_RELEASE) ? rel_bytes : {2'b00, p4};
   assign sub_res = (sub_x > bytes_ff) ? 32'd0 : bytes_ff - sub_x;

   always_comb begin
      if (lost_ff) begin
         alloc_chk = ST_LOST;
      end else if (a_prec > 2'd1 || (a_prec == 2'd1 && a_len != 30'd0)) begin
         alloc_chk = ST_PRECISION;
      end else if (req_ff.req_width == 14'd0 || req_ff.req_height == 14'd0
                   || req_ff.req_width > 14'(MAX_EXTENT)
                   || req_ff.req_height > 14'(MAX_EXTENT)
                   || (a_len != 30'd0 && {1'b0, a_len} != a_bytes)) begin
         alloc_chk = ST_SIZE;
      end else if (!fits) begin
         alloc_chk = ST_BYTES;
      end else begin
         alloc_chk = ST_OK;
      end
   end

   // The sweep reads slot scan_ff and looks at the data in the next cycle under pend_addr_ff.
   assign scan_more = scan_ff < hw_ff;
   assign free_hit  = is_alloc && pend_ff && !ent.live && ent.generation != GEN_MAX;
   assign clr_we    = cmd.step && pend_ff && !is_alloc;

   assign stat.defer = (is_alloc && alloc_chk == ST_OK)
                       || (req_ff.opcode == OP_BEGIN_FRAME && !lost_ff);
   assign stat.sweep_end = free_hit || (!pend_ff && !scan_more);

   always_comb begin
      new_attrs = 5'd0;
      if (is_depth) begin
         new_attrs[AB_DEPTHTEX] = 1'b1;
      end else begin
         new_attrs[AB_PREC]   = (a_prec == 2'd1);
         new_attrs[AB_TARGET] = (a_len == 30'd0);
      end
      new_ent.live       = 1'b1;
      new_ent.generation = found_ff ? found_gen_ff : 32'd0;
      new_ent.owners     = 32'd1;
      new_ent.width      = req_ff.req_width;
      new_ent.height     = req_ff.req_height;
      new_ent.attrs      = new_attrs;
   end

   always_comb begin
      fin_st    = ST_OK;
      fin_done  = 1'b0;
      fin_slot  = '0;
      fin_gen   = 32'd0;
      fin_we    = 1'b0;
      fin_addr  = req_ff.handle_slot;
      fin_wdata = ent;
      hw_in     = hw_ff;
      live_in   = live_ff;
      bytes_in  = bytes_ff;
      lost_in   = lost_ff;
      case (req_ff.opcode)
         OP_ALLOC, OP_ALLOC_DEPTH: begin
            if (!cmd.phase2) begin
               fin_st = alloc_chk;
            end else if (!found_ff && hw_ff >= CNT_W'(SLOT_COUNT)) begin
               fin_st = ST_SLOTS;
            end else begin
               fin_we    = 1'b1;
               fin_addr  = found_ff ? found_slot_ff : hw_ff[IDX_W-1:0];
               fin_wdata = new_ent;
               fin_slot  = fin_addr;
               fin_gen   = new_ent.generation;
               bytes_in  = add_sum[31:0];
               live_in   = live_ff + 1'b1;
               if (!found_ff) begin
                  hw_in = hw_ff + 1'b1;
               end
            end
         end
         OP_RETAIN: begin
            if (lost_ff) begin
               fin_st = ST_LOST;
            end else if (!valid) begin
               fin_st = ST_STALE;
            end else if (ent.owners == GEN_MAX) begin
               fin_st = ST_OWNERS;
            end else begin
               fin_we = 1'b1;
               fin_wdata.owners = ent.owners + 32'd1;
            end
         end
         OP_RELEASE: begin
            if (own_ff) begin
               fin_we = 1'b1;
               fin_wdata.owners = ent.owners - 32'd1;
               if (ent.owners == 32'd1) begin
                  fin_wdata.live       = 1'b0;
                  fin_wdata.generation = ent.generation + 32'd1;
                  bytes_in = sub_res;
                  if (live_ff != '0) begin
                     live_in = live_ff - 1'b1;
                  end
                  fin_done = 1'b1;
               end
            end
         end
         OP_RESERVE: begin
            if (lost_ff) begin
               fin_st = ST_LOST;
            end else if (!valid || !ent.attrs[AB_TARGET]) begin
               fin_st = ST_TARGET;
            end else if (ent.attrs[AB_PLANE]) begin
               fin_st = ST_OK;
            end else if (!fits) begin
               fin_st = ST_BYTES;
            end else begin
               bytes_in = add_sum[31:0];
               fin_we   = 1'b1;
               fin_wdata.attrs[AB_PLANE] = 1'b1;
               fin_done = 1'b1;
            end
         end
         OP_DROP: begin
            if (own_ff && ent.attrs[AB_PLANE]) begin
               bytes_in = sub_res;
               fin_we   = 1'b1;
               fin_wdata.attrs[AB_PLANE] = 1'b0;
            end
         end
         OP_QUERY: begin
            if (!valid) begin
               fin_st = ST_STALE;
            end else begin
               fin_done = 1'b1;
            end
         end
         OP_MARK: begin
            if (valid) begin
               fin_we = 1'b1;
               fin_wdata.attrs[AB_SAMPLED] = 1'b1;
            end
         end
         OP_BEGIN_FRAME: begin
            if (lost_ff) begin
               fin_st = ST_LOST;
            end
         end
         OP_CHECK: begin
            if (lost_ff) begin
               fin_st = ST_LOST;
            end else if (!valid) begin
               fin_st = ST_STALE;
            end else if (ent.attrs[AB_TARGET] || ent.attrs[AB_DEPTHTEX]
                         || req_ff.upload_length != p4) begin
               fin_st = ST_UPLOAD;
            end else if (ent.attrs[AB_SAMPLED]) begin
               fin_st = ST_SAMPLED;
            end
         end
         OP_INVALIDATE: begin
            lost_in = 1'b1;
         end
         default: begin
            fin_st = ST_OK;
         end
      endcase
   end

   // Write port: the finishing update, or the sampled-mark clear of a frame sweep.
   always_comb begin
      ram_we    = cmd.finish && fin_we;
      ram_waddr = fin_addr;
      ram_wdata = fin_wdata;
      if (clr_we) begin
         ram_we    = 1'b1;
         ram_waddr = pend_addr_ff;
         ram_wdata = {ent[EW-1:AB_SAMPLED+1], 1'b0, ent[AB_SAMPLED-1:0]};
      end
      ram_re    = cmd.read || (cmd.step && scan_more);
      ram_raddr = cmd.read ? req_ff.handle_slot : scan_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_ff <= DEVICE_RESET;
         budget_ff <= BUDGET_RESET;
         hw_ff     <= '0;
         live_ff   <= '0;
         bytes_ff  <= 32'd0;
         lost_ff   <= 1'b0;
         scan_ff   <= '0;
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_DEVICE_ID) begin
               device_ff <= csr_wdata[15:0];
            end else begin
               budget_ff <= csr_wdata;
            end
         end
         if (cmd.finish) begin
            hw_ff    <= hw_in;
            live_ff  <= live_in;
            bytes_ff <= bytes_in;
            lost_ff  <= lost_in;
         end
         if (cmd.sweep_start) begin
            scan_ff  <= '0;
            pend_ff  <= 1'b0;
            found_ff <= 1'b0;
         end else if (cmd.step) begin
            if (scan_more) begin
               scan_ff <= scan_ff + 1'b1;
            end
            pend_ff <= scan_more;
            if (free_hit) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      if (cmd.mult) begin
         own_ff  <= req_ff.handle_device == device_ff
                    && {1'b0, req_ff.handle_slot} < hw_ff
                    && ent.live && ent.generation == req_ff.handle_generation;
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.step) begin
         pend_addr_ff <= scan_ff[IDX_W-1:0];
         if (free_hit) begin
            found_slot_ff <= pend_addr_ff;
            found_gen_ff  <= ent.generation;
         end
      end
      if (cmd.finish) begin
         rsp_ff.status         <= fin_st;
         rsp_ff.done_flag      <= fin_done;
         rsp_ff.out_slot       <= fin_slot;
         rsp_ff.out_generation <= fin_gen;
         rsp_ff.out_width      <= (req_ff.opcode == OP_QUERY && valid) ? ent.width : 14'd0;
         rsp_ff.out_height     <= (req_ff.opcode == OP_QUERY && valid) ? ent.height : 14'd0;
         rsp_ff.out_precision  <= req_ff.opcode == OP_QUERY && valid && ent.attrs[AB_PREC];
         rsp_ff.out_is_depth   <= req_ff.opcode == OP_QUERY && valid
                                  && ent.attrs[AB_DEPTHTEX];
         rsp_ff.out_is_target  <= req_ff.opcode == OP_QUERY && valid
                                  && ent.attrs[AB_TARGET];
         rsp_ff.live_textures  <= live_in;
         rsp_ff.texture_bytes  <= bytes_in;
      end
   end

   assign rsp_word = rsp_ff;
endmodule

// ===== rtl/core/generational_texture_slot_table.sv =====
// Channel   Direction  Handshake          Word
// req_chan  in         valid / ready      command: opcode, handle, extent, precision, length
// rsp_chan  out        valid / ready      result: status, handle, slot contents, statistics
// csr_*     in         write enable only  register index and 32-bit data
//
// Most commands pass through the accepting state, entry read, multiply, then the
// update, which loads the result register once the result port is free.
// Allocation and begin-frame add a sweep over the slot RAM, one entry per cycle,
// and a finishing state.
// Allocation ends its sweep at the first free slot whose generation is below GEN_MAX.
// One command is in work at a time; a new command is taken once the last result is loaded.
// Reset is synchronous; the slot RAM needs no clearing since the high-water mark bounds it.
// A stalled result port holds the finished word and the next command waits in the update.
module generational_texture_slot_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   gtst_req_if.sink    req_chan,
   gtst_rsp_if.source  rsp_chan
);
   import gtst_pkg::*;

   dp_cmd_type   cmd;
   dp_stat_type  stat;
   req_word_type req_word;
   rsp_word_type rsp_word;

   assign req_word.opcode            = req_chan.opcode;
   assign req_word.handle_device     = req_chan.handle_device;
   assign req_word.handle_slot       = req_chan.handle_slot;
   assign req_word.handle_generation = req_chan.handle_generation;
   assign req_word.req_width         = req_chan.req_width;
   assign req_word.req_height        = req_chan.req_height;
   assign req_word.req_precision     = req_chan.req_precision;
   assign req_word.upload_length     = req_chan.upload_length;

   gtst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   gtst_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_word     (req_word),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_word     (rsp_word)
   );

   assign rsp_chan.status         = rsp_word.status;
   assign rsp_chan.done_flag      = rsp_word.done_flag;
   assign rsp_chan.out_slot       = rsp_word.out_slot;
   assign rsp_chan.out_generation = rsp_word.out_generation;
   assign rsp_chan.out_width      = rsp_word.out_width;
   assign rsp_chan.out_height     = rsp_word.out_height;
   assign rsp_chan.out_precision  = rsp_word.out_precision;
   assign rsp_chan.out_is_depth   = rsp_word.out_is_depth;
   assign rsp_chan.out_is_target  = rsp_word.out_is_target;
   assign rsp_chan.live_textures  = rsp_word.live_textures;
   assign rsp_chan.texture_bytes  = rsp_word.texture_bytes;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("command taken while the previous one is still in work");

   a_finish_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result loaded over a word that was not taken");

   a_finish_shows_word: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_chan.valid)
      else $error("finished command did not present a result word");
`endif
endmodule

// ===== tb/generational_texture_slot_table_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the generational texture slot table: directed and random commands,
// a behavioral slot ledger predicts every result word. Depends on gtst_pkg,
// gtst_req_if, gtst_rsp_if and the block itself.
module generational_texture_slot_table_tb;
   import gtst_pkg::*;

   localparam int IDLE_LIMIT = 40000;

   typedef struct {
      logic [9:0]  slot;
      logic [31:0] gen;
   } handle_type;

   class texture_ledger;
      logic [15:0] dev_id;
      logic [31:0] budget;
      bit          live[SLOT_COUNT];
      logic [31:0] gen[SLOT_COUNT];
      logic [31:0] owners[SLOT_COUNT];
      logic [13:0] wid[SLOT_COUNT];
      logic [13:0] hgt[SLOT_COUNT];
      logic [4:0]  attrs[SLOT_COUNT];
      int unsigned high_water;
      int unsigned live_count;
      logic [31:0] bytes_used;
      bit          lost;
      rsp_word_type expected_words[$];
      handle_type  handles[$];
      handle_type  last_handle;
      int          fails;

      function new();
         dev_id = DEVICE_RESET;
         budget = BUDGET_RESET;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            live[i] = 0; gen[i] = 0; owners[i] = 0; wid[i] = 0; hgt[i] = 0; attrs[i] = 0;
         end
         high_water = 0; live_count = 0; bytes_used = 0; lost = 0; fails = 0;
      endfunction

      function bit fits(longint unsigned b);
         return longint'(bytes_used) + b <= longint'(budget);
      endfunction

      function void take_bytes(longint unsigned b);
         if (b > bytes_used) bytes_used = 0;
         else bytes_used = bytes_used - 32'(b);
      endfunction

      function logic [3:0] alloc(longint unsigned w, longint unsigned h, logic [1:0] p,
                                 longint unsigned len, bit depth, output int s);
         longint unsigned b;
         if (p > 1 || (p == 1 && len != 0)) return ST_PRECISION;
         b = w * h * ((p == 1) ? 8 : 4);
         if (w == 0 || h == 0 || w > MAX_EXTENT || h > MAX_EXTENT || (len != 0 && len != b))
            return ST_SIZE;
         if (!fits(b)) return ST_BYTES;
         for (s = 0; s < high_water; s++)
            if (!live[s] && gen[s] != GEN_MAX) break;
         if (s >= high_water) begin
            if (high_water >= SLOT_COUNT) return ST_SLOTS;
            s = high_water;
            high_water++;
         end
         wid[s] = 14'(w); hgt[s] = 14'(h); live[s] = 1; owners[s] = 1;
         if (depth) attrs[s] = 5'd1 << AB_DEPTHTEX;
         else attrs[s] = ((p == 1) ? (5'd1 << AB_PREC) : 5'd0) |
                         ((len == 0) ? (5'd1 << AB_TARGET) : 5'd0);
         bytes_used = bytes_used + 32'(b);
         live_count++;
         return ST_OK;
      endfunction

      // Computes the result of one accepted command and updates the slot state.
      function void note(req_word_type c);
         rsp_word_type r;
         bit own, ok;
         int s, ns;
         longint unsigned b;
         handle_type nh;
         r = '0;
         own = c.handle_device == dev_id && c.handle_slot < high_water &&
               live[c.handle_slot] && gen[c.handle_slot] == c.handle_generation;
         ok = own && !lost;
         s = own ? int'(c.handle_slot) : 0;
         case (c.opcode)
            OP_ALLOC, OP_ALLOC_DEPTH: begin
               if (lost) r.status = ST_LOST;
               else begin
                  if (c.opcode == OP_ALLOC_DEPTH)
                     r.status = alloc(c.req_width, c.req_height, 2'd0, 0, 1, ns);
                  else
                     r.status = alloc(c.req_width, c.req_height, c.req_precision,
                                      c.upload_length, 0, ns);
                  if (r.status == ST_OK) begin
                     r.out_slot = 10'(ns); r.out_generation = gen[ns];
                     nh.slot = 10'(ns); nh.gen = gen[ns];
                     last_handle = nh;
                     handles.push_back(nh);
                     if (handles.size() > 64) handles.delete($urandom_range(0, 63));
                  end
               end
            end
            OP_RETAIN: begin
               if (lost) r.status = ST_LOST;
               else if (!ok) r.status = ST_STALE;
               else if (owners[s] == GEN_MAX) r.status = ST_OWNERS;
               else owners[s]++;
            end
            OP_RELEASE: begin
               if (own) begin
                  owners[s]--;
                  if (owners[s] == 0) begin
                     b = longint'(wid[s]) * hgt[s] * ((attrs[s][AB_PREC] ? 8 : 4) +
                                                      (attrs[s][AB_PLANE] ? 4 : 0));
                     take_bytes(b);
                     live[s] = 0;
                     gen[s]++;
                     if (live_count != 0) live_count--;
                     r.done_flag = 1;
                  end
               end
            end
            OP_RESERVE: begin
               if (lost) r.status = ST_LOST;
               else if (!ok || !attrs[s][AB_TARGET]) r.status = ST_TARGET;
               else if (!attrs[s][AB_PLANE]) begin
                  b = longint'(wid[s]) * hgt[s] * 4;
                  if (!fits(b)) r.status = ST_BYTES;
                  else begin
                     bytes_used = bytes_used + 32'(b);
                     attrs[s][AB_PLANE] = 1;
                     r.done_flag = 1;
                  end
               end
            end
            OP_DROP: begin
               if (own && attrs[s][AB_PLANE]) begin
                  take_bytes(longint'(wid[s]) * hgt[s] * 4);
                  attrs[s][AB_PLANE] = 0;
               end
            end
            OP_QUERY: begin
               if (!ok) r.status = ST_STALE;
               else begin
                  r.done_flag = 1;
                  r.out_width = wid[s]; r.out_height = hgt[s];
                  r.out_precision = attrs[s][AB_PREC];
                  r.out_is_depth = attrs[s][AB_DEPTHTEX];
                  r.out_is_target = attrs[s][AB_TARGET];
               end
            end
            OP_MARK: if (ok) attrs[s][AB_SAMPLED] = 1;
            OP_BEGIN_FRAME: begin
               if (lost) r.status = ST_LOST;
               else for (int i = 0; i < SLOT_COUNT; i++) attrs[i][AB_SAMPLED] = 0;
            end
            OP_CHECK: begin
               if (lost) r.status = ST_LOST;
               else if (!ok) r.status = ST_STALE;
               else if (attrs[s][AB_TARGET] || attrs[s][AB_DEPTHTEX] ||
                        longint'(c.upload_length) != longint'(wid[s]) * hgt[s] * 4)
                  r.status = ST_UPLOAD;
               else if (attrs[s][AB_SAMPLED]) r.status = ST_SAMPLED;
            end
            OP_INVALIDATE: lost = 1;
            default: ;
         endcase
         r.live_textures = 11'(live_count);
         r.texture_bytes = bytes_used;
         expected_words.push_back(r);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
         fails++;
      endtask

      task cmp(string what, logic [31:0] got, logic [31:0] want);
         if (got !== want) report(what, got, want);
      endtask

      task check(rsp_word_type g);
         rsp_word_type e;
         if (expected_words.size() == 0) begin
            report("unexpected result word", g.status, 0);
            return;
         end
         e = expected_words.pop_front();
         cmp("status", g.status, e.status);
         cmp("done_flag", g.done_flag, e.done_flag);
         cmp("out_slot", g.out_slot, e.out_slot);
         cmp("out_generation", g.out_generation, e.out_generation);
         cmp("out_width", g.out_width, e.out_width);
         cmp("out_height", g.out_height, e.out_height);
         cmp("out_precision", g.out_precision, e.out_precision);
         cmp("out_is_depth", g.out_is_depth, e.out_is_depth);
         cmp("out_is_target", g.out_is_target, e.out_is_target);
         cmp("live_textures", g.live_textures, e.live_textures);
         cmp("texture_bytes", g.texture_bytes, e.texture_bytes);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write_en = 0;
   logic        csr_index = CSR_DEVICE_ID;
   logic [31:0] csr_wdata = 0;

   gtst_req_if req_chan();
   gtst_rsp_if rsp_chan();

   texture_ledger ledger = new();
   int  idle_cycles = 0;
   int  burst_left = 0;
   bit  no_gaps = 0;
   int  stall_mode = 0;
   int  stall_left = 0;
   int  cycle_count = 0;

   generational_texture_slot_table dut (
      .clock(clock), .reset(reset), .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      req_chan.opcode = 0;
      req_chan.handle_device = 0;
      req_chan.handle_slot = 0;
      req_chan.handle_generation = 0;
      req_chan.req_width = 0;
      req_chan.req_height = 0;
      req_chan.req_precision = 0;
      req_chan.upload_length = 0;
      rsp_chan.ready = 0;
   end

   // Accepted words on both channels, sampled before the edge updates them.
   always @(posedge clock) begin
      rsp_word_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            ledger.note('{req_chan.opcode, req_chan.handle_device, req_chan.handle_slot,
                          req_chan.handle_generation, req_chan.req_width,
                          req_chan.req_height, req_chan.req_precision,
                          req_chan.upload_length});
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.status, rsp_chan.done_flag, rsp_chan.out_slot,
                    rsp_chan.out_generation, rsp_chan.out_width, rsp_chan.out_height,
                    rsp_chan.out_precision, rsp_chan.out_is_depth, rsp_chan.out_is_target,
                    rsp_chan.live_textures, rsp_chan.texture_bytes};
            ledger.check(got);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else if (req_chan.valid || ledger.expected_words.size() != 0)
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // The result side stalls in modes picked at random, from always ready to a duty pattern.
   always @(negedge clock) begin
      cycle_count++;
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(50, 300);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_chan.ready <= 1;
         1: rsp_chan.ready <= $urandom_range(0, 3) != 0;
         2: rsp_chan.ready <= $urandom_range(0, 1);
         default: rsp_chan.ready <= (cycle_count % 16) < 5;
      endcase
   end

   task send(req_word_type w);
      @(negedge clock);
      if (burst_left == 0 && !no_gaps) begin
         req_chan.valid = 0;
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(10, 20) : $urandom_range(1, 4))
            @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      req_chan.opcode = w.opcode;
      req_chan.handle_device = w.handle_device;
      req_chan.handle_slot = w.handle_slot;
      req_chan.handle_generation = w.handle_generation;
      req_chan.req_width = w.req_width;
      req_chan.req_height = w.req_height;
      req_chan.req_precision = w.req_precision;
      req_chan.upload_length = w.upload_length;
      req_chan.valid = 1;
      do @(posedge clock); while (!req_chan.ready);
      if (burst_left > 0) burst_left--;
   endtask

   task cmd(logic [3:0] op, handle_type h, int w, int ht, int p, int len);
      send('{op, ledger.dev_id, h.slot, h.gen, w[13:0], ht[13:0], p[1:0], len[29:0]});
   endtask

   // Waits until every expected word has come back, then lets the block settle.
   task drain();
      @(negedge clock);
      req_chan.valid = 0;
      while (ledger.expected_words.size() != 0) @(posedge clock);
      repeat (1100) @(posedge clock);
   endtask

   task csr_write(logic idx, logic [31:0] data);
      @(negedge clock);
      csr_write_en = 1; csr_index = idx; csr_wdata = data;
      @(negedge clock);
      csr_write_en = 0;
      if (idx == CSR_DEVICE_ID) ledger.dev_id = data[15:0];
      else ledger.budget = data;
   endtask

   function int pick_extent();
      case ($urandom_range(0, 19))
         0: return 0;
         1: return MAX_EXTENT;
         2: return MAX_EXTENT + 1;
         3: return $urandom_range(0, 16383);
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   function req_word_type random_cmd();
      req_word_type c;
      handle_type h;
      int k;
      k = $urandom_range(0, 99);
      if (k < 20) c.opcode = OP_ALLOC;
      else if (k < 28) c.opcode = OP_ALLOC_DEPTH;
      else if (k < 38) c.opcode = OP_RETAIN;
      else if (k < 53) c.opcode = OP_RELEASE;
      else if (k < 61) c.opcode = OP_RESERVE;
      else if (k < 67) c.opcode = OP_DROP;
      else if (k < 79) c.opcode = OP_QUERY;
      else if (k < 87) c.opcode = OP_MARK;
      else if (k < 90) c.opcode = OP_BEGIN_FRAME;
      else if (k < 98) c.opcode = OP_CHECK;
      else c.opcode = 4'($urandom_range(OP_INVALIDATE + 1, 15));
      if (ledger.handles.size() != 0 && $urandom_range(0, 9) < 8)
         h = ledger.handles[$urandom_range(0, ledger.handles.size() - 1)];
      else begin
         h.slot = 10'($urandom_range(0, 1023));
         h.gen = $urandom;
      end
      if ($urandom_range(0, 15) == 0) h.gen = h.gen + 1;
      c.handle_device = ($urandom_range(0, 15) == 0) ? 16'($urandom) : ledger.dev_id;
      c.handle_slot = h.slot;
      c.handle_generation = h.gen;
      c.req_width = 14'(pick_extent());
      c.req_height = 14'(pick_extent());
      k = $urandom_range(0, 9);
      c.req_precision = (k < 6) ? 2'd0 : (k < 9) ? 2'd1 : 2'($urandom_range(2, 3));
      k = $urandom_range(0, 9);
      if (c.opcode == OP_CHECK && k < 7)
         c.upload_length = 30'(ledger.wid[h.slot] * ledger.hgt[h.slot] * 4);
      else if (k < 5) c.upload_length = 0;
      else if (k < 8) c.upload_length = 30'(c.req_width * c.req_height * 4);
      else c.upload_length = 30'($urandom);
      return c;
   endfunction

   task random_run(int n);
      repeat (n) send(random_cmd());
   endtask

   initial begin
      handle_type tgt, img, dep, junk;
      int fill;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      csr_write(CSR_DEVICE_ID, 32'd1);
      csr_write(CSR_BYTE_BUDGET, BUDGET_RESET);

      // Directed: extremes of size and budget, every opcode but invalidate, and the error paths.
      junk.slot = 10'h3FF; junk.gen = 32'hFFFF_FFFF;
      cmd(OP_ALLOC, junk, MAX_EXTENT, MAX_EXTENT, 0, 0);
      tgt = ledger.last_handle;
      cmd(OP_RELEASE, tgt, 0, 0, 0, 0);
      cmd(OP_ALLOC, junk, 16, 16, 1, 2048);
      cmd(OP_ALLOC, junk, 16, 16, 3, 0);
      cmd(OP_ALLOC, junk, 0, 16, 0, 0);
      cmd(OP_ALLOC, junk, 16, MAX_EXTENT + 1, 0, 0);
      cmd(OP_ALLOC, junk, 16, 16, 0, 100);
      cmd(OP_ALLOC, junk, MAX_EXTENT, MAX_EXTENT, 1, 0);
      cmd(OP_ALLOC, junk, 1, 1, 1, 0);
      tgt = ledger.last_handle;
      cmd(OP_ALLOC_DEPTH, junk, 8, 4, 3, 999);
      dep = ledger.last_handle;
      cmd(OP_ALLOC, junk, 4, 4, 0, 64);
      img = ledger.last_handle;
      cmd(OP_RETAIN, tgt, 0, 0, 0, 0);
      cmd(OP_QUERY, tgt, 0, 0, 0, 0);
      cmd(OP_RESERVE, tgt, 0, 0, 0, 0);
      cmd(OP_RESERVE, tgt, 0, 0, 0, 0);
      cmd(OP_RESERVE, dep, 0, 0, 0, 0);
      cmd(OP_DROP, tgt, 0, 0, 0, 0);
      cmd(OP_CHECK, tgt, 0, 0, 0, 4);
      cmd(OP_CHECK, img, 0, 0, 0, 64);
      cmd(OP_MARK, img, 0, 0, 0, 0);
      cmd(OP_CHECK, img, 0, 0, 0, 64);
      cmd(OP_BEGIN_FRAME, junk, 0, 0, 0, 0);
      cmd(OP_CHECK, img, 0, 0, 0, 64);
      cmd(OP_RELEASE, junk, 0, 0, 0, 0);
      cmd(OP_QUERY, junk, 0, 0, 0, 0);
      cmd(4'd15, junk, 0, 0, 0, 0);
      random_run(80);
      drain();

      csr_write(CSR_DEVICE_ID, 32'hFFFF);
      csr_write(CSR_BYTE_BUDGET, 32'hFFFF_FFFF);
      random_run(60);
      drain();

      // A budget below the bytes in use must refuse every growth.
      csr_write(CSR_DEVICE_ID, 32'd1);
      csr_write(CSR_BYTE_BUDGET, 32'd0);
      random_run(30);
      drain();
      csr_write(CSR_BYTE_BUDGET, ledger.bytes_used + 32'd4096);
      random_run(50);
      drain();

      // Fill the table until no slot is left, with the sender never pausing.
      csr_write(CSR_BYTE_BUDGET, 32'hFFFF_FFFF);
      no_gaps = 1;
      fill = SLOT_COUNT - ledger.live_count + 2;
      repeat (fill) cmd(OP_ALLOC, junk, 1, 1, 0, 0);
      no_gaps = 0;
      cmd(OP_RELEASE, ledger.last_handle, 0, 0, 0, 0);
      cmd(OP_ALLOC, junk, 2, 2, 0, 0);
      random_run(40);
      drain();

      // Once the device is lost it stays lost for the rest of the run.
      cmd(OP_INVALIDATE, junk, 0, 0, 0, 0);
      random_run(30);
      drain();

      if (ledger.fails == 0 && ledger.expected_words.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

// ===== generational_texture_slot_table.f =====
rtl/core/gtst_pkg.sv
rtl/core/gtst_req_if.sv
rtl/core/gtst_rsp_if.sv
rtl/core/gtst_ram.sv
rtl/core/gtst_ctrl.sv
rtl/core/gtst_dpath.sv
rtl/core/generational_texture_slot_table.sv
tb/generational_texture_slot_table_tb.sv
